### rtl/swstk_pkg.sv
`timescale 1ns / 1ps

package swstk_pkg;

  // Sizing of the pool
  localparam int STACK_DEPTH = 1024;
  localparam int REQUESTERS  = 8;
  localparam int WORD_BITS   = 32;

  // Fixed field widths of the channels
  localparam int CMD_W      = 2;
  localparam int REQ_W      = 3;
  localparam int PORT_WORD_W = 32;

  // Derived widths
  localparam int PTR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int REQ_IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_code_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input beat, start memory reads
    logic commit;   // apply the command, load the result register
  } dp_ctl_t;

endpackage

### rtl/swstk_if.sv
`timescale 1ns / 1ps

// Command channel
interface swstk_in_if;
  logic                               valid;
  logic                               ready;
  logic [swstk_pkg::CMD_W-1:0]        cmd;
  logic [swstk_pkg::REQ_W-1:0]        requester;
  logic [swstk_pkg::PORT_WORD_W-1:0]  push_word;

  modport source (output valid, cmd, requester, push_word, input ready);
  modport sink   (input valid, cmd, requester, push_word, output ready);
endinterface

// Result channel
interface swstk_out_if;
  logic                               valid;
  logic                               ready;
  logic                               pop_found;
  logic [swstk_pkg::PORT_WORD_W-1:0]  pop_word;
  logic                               all_done;
  logic                               overflow;

  modport source (output valid, pop_found, pop_word, all_done, overflow, input ready);
  modport sink   (input valid, pop_found, pop_word, all_done, overflow, output ready);
endinterface

### rtl/swstk_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module swstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/swstk_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: fetch cycle, then execute once the result register is free
module swstk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output swstk_pkg::dp_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_free    = !out_valid_r || out_ready;
  assign ctl.capture = in_valid && in_ready;
  assign ctl.commit  = (state_r == ST_EXEC) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.capture) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (ctl.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/swstk_dp.sv
`timescale 1ns / 1ps

// Datapath: stack and slot memories, flags, result register
module swstk_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swstk_pkg::dp_ctl_t                  ctl,
  input  logic [swstk_pkg::CMD_W-1:0]         in_cmd,
  input  logic [swstk_pkg::REQ_W-1:0]         in_requester,
  input  logic [swstk_pkg::PORT_WORD_W-1:0]   in_push_word,
  output logic                                out_pop_found,
  output logic [swstk_pkg::PORT_WORD_W-1:0]   out_pop_word,
  output logic                                out_all_done,
  output logic                                out_overflow
);

  // Captured command
  logic [swstk_pkg::CMD_W-1:0]       cmd_r;
  logic [swstk_pkg::REQ_W-1:0]       req_r;
  logic [swstk_pkg::WORD_BITS-1:0]   word_r;

  // Pool state
  logic [swstk_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [swstk_pkg::REQUESTERS-1:0]  slot_full_r, slot_full_nxt;
  logic [swstk_pkg::REQUESTERS-1:0]  busy_r, busy_nxt;

  // Result register
  logic                              found_r, found_nxt;
  logic [swstk_pkg::PORT_WORD_W-1:0] pword_r, pword_nxt;
  logic                              done_r, done_nxt;
  logic                              ovf_r, ovf_nxt;

  // Memory ports
  logic [swstk_pkg::REQ_IDX_W-1:0]   in_idx, idx_r;
  logic [swstk_pkg::PTR_W-1:0]       stk_raddr, stk_waddr;
  logic [swstk_pkg::WORD_BITS-1:0]   stk_rdata, slot_rdata;
  logic                              stk_we, slot_we;
  logic                              in_range;

  assign in_idx    = swstk_pkg::REQ_IDX_W'(in_requester);
  assign idx_r     = swstk_pkg::REQ_IDX_W'(req_r);
  assign stk_raddr = swstk_pkg::PTR_W'(fill_r - swstk_pkg::FILL_W'(1));
  assign stk_waddr = swstk_pkg::PTR_W'(fill_r);
  assign in_range  = (int'(req_r) < swstk_pkg::REQUESTERS);

  swstk_ram #(
    .WIDTH (swstk_pkg::WORD_BITS),
    .DEPTH (swstk_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (word_r),
    .re    (ctl.capture),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  swstk_ram #(
    .WIDTH (swstk_pkg::WORD_BITS),
    .DEPTH (swstk_pkg::REQUESTERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (idx_r),
    .wdata (word_r),
    .re    (ctl.capture),
    .raddr (in_idx),
    .rdata (slot_rdata)
  );

  // Command execution
  always_comb begin
    fill_nxt      = fill_r;
    slot_full_nxt = slot_full_r;
    busy_nxt      = busy_r;
    found_nxt     = 1'b0;
    pword_nxt     = '0;
    done_nxt      = 1'b0;
    ovf_nxt       = 1'b0;
    stk_we        = 1'b0;
    slot_we       = 1'b0;
    if (ctl.commit && in_range) begin
      case (swstk_pkg::cmd_code_t'(cmd_r))
        swstk_pkg::CMD_PUSH: begin
          if (!slot_full_r[idx_r]) begin
            slot_we              = 1'b1;
            slot_full_nxt[idx_r] = 1'b1;
          end else if (fill_r < swstk_pkg::FILL_W'(swstk_pkg::STACK_DEPTH)) begin
            stk_we   = 1'b1;
            fill_nxt = fill_r + swstk_pkg::FILL_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        swstk_pkg::CMD_POP: begin
          if (slot_full_r[idx_r]) begin
            slot_full_nxt[idx_r] = 1'b0;
            busy_nxt[idx_r]      = 1'b1;
            found_nxt            = 1'b1;
            pword_nxt            = swstk_pkg::PORT_WORD_W'(slot_rdata);
          end else if (fill_r != '0) begin
            fill_nxt        = fill_r - swstk_pkg::FILL_W'(1);
            busy_nxt[idx_r] = 1'b1;
            found_nxt       = 1'b1;
            pword_nxt       = swstk_pkg::PORT_WORD_W'(stk_rdata);
          end else begin
            busy_nxt[idx_r] = 1'b0;
          end
        end
        swstk_pkg::CMD_CHECK: begin
          done_nxt = !slot_full_r[idx_r] && (fill_r == '0) && (busy_r == '0);
        end
        default: ;
      endcase
    end
  end

  // Capture and result registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= in_cmd;
      req_r  <= in_requester;
      word_r <= swstk_pkg::WORD_BITS'(in_push_word);
    end
    if (ctl.commit) begin
      found_r <= found_nxt;
      pword_r <= pword_nxt;
      done_r  <= done_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Pool control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      slot_full_r <= '0;
      busy_r      <= '0;
    end else begin
      fill_r      <= fill_nxt;
      slot_full_r <= slot_full_nxt;
      busy_r      <= busy_nxt;
    end
  end

  assign out_pop_found = found_r;
  assign out_pop_word  = pword_r;
  assign out_all_done  = done_r;
  assign out_overflow  = ovf_r;

endmodule

### rtl/shared_work_stack_with_local_slots.sv
`timescale 1ns / 1ps
// A result beat is registered as its command leaves the execute state.
// Each command is captured (with memory read), then executed; the next one is
// accepted only after that, and execute waits while an earlier result beat is still unread.
// Reset (synchronous, rst_n low): stack fill, slot-full and busy flags clear;
// memories are not cleared and the block is ready right after reset.
module shared_work_stack_with_local_slots (
  input  logic         clk,
  input  logic         rst_n,
  swstk_in_if.sink     in_ch,
  swstk_out_if.source  out_ch
);

  swstk_pkg::dp_ctl_t ctl;

  swstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  swstk_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_cmd        (in_ch.cmd),
    .in_requester  (in_ch.requester),
    .in_push_word  (in_ch.push_word),
    .out_pop_found (out_ch.pop_found),
    .out_pop_word  (out_ch.pop_word),
    .out_all_done  (out_ch.all_done),
    .out_overflow  (out_ch.overflow)
  );

endmodule
